>>> rtl/sacl_pkg.sv
package sacl_pkg;
	localparam int MAX_WAYS_D = 8;
	localparam int MAX_SETS_D = 256;
	localparam int ADDR_BITS_D = 32;
	localparam int TAG_W = 32;
	localparam int STAMP_W = 32;
	localparam int CNT_W = 32;
	localparam logic [1:0] OUT_HIT = 2'd0;
	localparam logic [1:0] OUT_CLEAN = 2'd1;
	localparam logic [1:0] OUT_DIRTY = 2'd2;
	localparam logic [1:0] REG_OFFSET = 2'd0;
	localparam logic [1:0] REG_SETS = 2'd1;
	localparam logic [1:0] REG_WAYS = 2'd2;

	typedef struct packed {
		logic           store;
		logic [31:0]    set;
		logic [TAG_W-1:0] tag;
		logic [STAMP_W-1:0] stamp;
	} req_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction
endpackage

>>> rtl/sacl_front.sv
module sacl_front #(
	parameter int MAX_SETS = sacl_pkg::MAX_SETS_D,
	parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_D
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  store,
	input  logic [ADDR_BITS-1:0]  address,
	input  logic [31:0]           op_index,
	input  logic [3:0]            offset_bits,
	input  logic [3:0]            set_bits,
	output logic                  q_valid,
	input  logic                  q_ready,
	output sacl_pkg::req_t        q_req
);
	localparam int MSB = $clog2(MAX_SETS + 1) - 1;
	localparam int DEPTH = 2;

	logic [3:0] sb;
	logic [5:0] shift;
	logic [ADDR_BITS-1:0] a_sh, t_sh, smask;
	sacl_pkg::req_t cls;
	sacl_pkg::req_t fifo_q [DEPTH];
	logic [1:0] cnt_q;
	logic wr_ptr_q, rd_ptr_q;

	always_comb begin
		sb = (set_bits > 4'(MSB)) ? 4'(MSB) : set_bits;
		shift = 6'(offset_bits) + 6'(sb);
		a_sh = address >> offset_bits;
		smask = ~({ADDR_BITS{1'b1}} << sb);
		t_sh = (shift < 6'(ADDR_BITS)) ? (address >> shift) : '0;
		cls.store = store;
		cls.set = 32'(a_sh & smask);
		cls.tag = sacl_pkg::TAG_W'(t_sh);
		cls.stamp = op_index;
	end

	assign in_ready = (cnt_q != 2'(DEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) wr_ptr_q <= ~wr_ptr_q;
			if (q_valid && q_ready) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

>>> rtl/sacl_back.sv
module sacl_back #(
	parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_D,
	parameter int MAX_SETS = sacl_pkg::MAX_SETS_D
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  sacl_pkg::req_t   q_req,
	input  logic [3:0]       ways_in_use,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [263:0]     out_data
);
	localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int ENT_W = 2 + sacl_pkg::TAG_W + sacl_pkg::STAMP_W;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001, ST_IDLE = 4'b0010, ST_LOOK = 4'b0100, ST_OUT = 4'b1000
	} st_t;
	st_t st_q;

	logic [ENT_W-1:0] mem [MAX_WAYS][MAX_SETS];
	logic [ENT_W-1:0] rd_s1 [MAX_WAYS];
	logic [SW-1:0] clr_q;
	sacl_pkg::req_t req_q;
	logic [31:0] ld_q, stc_q, rm_q, wm_q, drm_q, dwm_q;
	logic [70:0] res_q;

	logic [4:0] nways;
	logic [WW-1:0] w;
	logic hit, empty;
	logic [1:0] outcome;
	logic p_v, p_d;
	logic [31:0] p_t, p_u;
	logic [SW-1:0] set_a, req_set;

	assign req_set = SW'(req_q.set);
	assign set_a = SW'(q_req.set);

	always_comb begin
		nways = (ways_in_use == 4'd0) ? 5'd1 :
			(5'(ways_in_use) > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : 5'(ways_in_use);
		hit = 1'b0;
		empty = 1'b0;
		w = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (5'(i) < nways && rd_s1[i][ENT_W-1] &&
				rd_s1[i][ENT_W-3 -: 32] == req_q.tag) begin
				hit = 1'b1;
				w = WW'(i);
			end
		end
		if (!hit) begin
			for (int i = MAX_WAYS - 1; i >= 0; i--) begin
				if (5'(i) < nways && !rd_s1[i][ENT_W-1]) begin
					empty = 1'b1;
					w = WW'(i);
				end
			end
			if (!empty) begin
				w = '0;
				for (int i = 1; i < MAX_WAYS; i++) begin
					if (5'(i) < nways && rd_s1[i][31:0] < rd_s1[w][31:0]) w = WW'(i);
				end
			end
		end
		p_v = rd_s1[w][ENT_W-1];
		p_d = rd_s1[w][ENT_W-2];
		p_t = p_v ? rd_s1[w][ENT_W-3 -: 32] : '0;
		p_u = rd_s1[w][31:0];
		outcome = hit ? sacl_pkg::OUT_HIT : (p_d ? sacl_pkg::OUT_DIRTY : sacl_pkg::OUT_CLEAN);
	end

	assign q_ready = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign out_data = {1'b0, dwm_q, drm_q, wm_q, rm_q, stc_q, ld_q, res_q};

	always_ff @(posedge clk) begin
		if (st_q == ST_CLEAR) begin
			for (int i = 0; i < MAX_WAYS; i++) mem[i][clr_q] <= '0;
		end else if (st_q == ST_LOOK) begin
			mem[w][req_set] <= {1'b1, (hit ? p_d : 1'b0) | req_q.store,
				(hit ? p_t : req_q.tag), req_q.stamp};
		end
		if (q_valid && q_ready) begin
			for (int i = 0; i < MAX_WAYS; i++) rd_s1[i] <= mem[i][set_a];
			req_q <= q_req;
		end
		if (st_q == ST_LOOK) begin
			res_q <= {p_u, p_t, p_d, p_v, 3'(w), outcome};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			{ld_q, stc_q, rm_q, wm_q, drm_q, dwm_q} <= '0;
		end else begin
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == 32'(MAX_SETS - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (q_valid) st_q <= ST_LOOK;
				ST_LOOK: begin
					if (req_q.store) begin
						stc_q <= sacl_pkg::sat_inc(stc_q);
						if (!hit) wm_q <= sacl_pkg::sat_inc(wm_q);
						if (!hit && p_d) dwm_q <= sacl_pkg::sat_inc(dwm_q);
					end else begin
						ld_q <= sacl_pkg::sat_inc(ld_q);
						if (!hit) rm_q <= sacl_pkg::sat_inc(rm_q);
						if (!hit && p_d) drm_q <= sacl_pkg::sat_inc(drm_q);
					end
					st_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/set_assoc_cache_lru_writeback_core.sv
// Cache directory: one load/store transaction in, one classification out.
// s_axis: tdata = {op_index, address, req_type} from bit 0, 72 bits.
// m_axis: tdata = outcome, way, prior_valid, prior_dirty, prior_tag,
// prior_last_used, then six saturating counters, zero-filled to 264 bits.
// Config: cfg_we/cfg_addr/cfg_data write offset_bits, set_bits, ways_in_use.
// A front stage splits the address into set and tag and pushes into a
// two-entry queue; the back end reads all ways of the set from memory,
// compares them, writes the updated way and presents the result.
// The back end takes one transaction at a time through its states IDLE
// (read of the way memory), LOOK (compare and write-back) and OUT, and
// takes no new one until the result is taken. The front keeps accepting
// while the queue has room. After reset the way memory is cleared, one set
// per cycle, up to MAX_SETS sets; meanwhile the queue takes up to two
// transactions. While m_axis_tready is low the result holds and the queue
// fills, then s_axis_tready drops.
module set_assoc_cache_lru_writeback_core #(
	parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_D,
	parameter int MAX_SETS = sacl_pkg::MAX_SETS_D
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [71:0]  s_axis_tdata,  // req_type, address, op_index
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [263:0] m_axis_tdata,  // outcome..dirty_write_miss_count
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [3:0]   cfg_data
);
	logic [3:0] offset_q, sets_q, ways_q;
	logic q_valid, q_ready;
	sacl_pkg::req_t q_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 4'd4;
			sets_q <= 4'd4;
			ways_q <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_addr)
				sacl_pkg::REG_OFFSET: offset_q <= cfg_data;
				sacl_pkg::REG_SETS: sets_q <= cfg_data;
				sacl_pkg::REG_WAYS: ways_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sacl_front #(.MAX_SETS(MAX_SETS), .ADDR_BITS(sacl_pkg::ADDR_BITS_D)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.store(s_axis_tdata[0]), .address(s_axis_tdata[32:1]),
		.op_index(s_axis_tdata[64:33]),
		.offset_bits(offset_q), .set_bits(sets_q),
		.q_valid, .q_ready, .q_req
	);

	sacl_back #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_req,
		.ways_in_use(ways_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata)
	);
endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
	typedef struct {
		logic [1:0]  outcome;
		logic [2:0]  way;
		logic        prior_valid;
		logic        prior_dirty;
		logic [31:0] prior_tag;
		logic [31:0] prior_last_used;
		logic [31:0] cnt [6];
	} access_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [263:0] m_axis_tdata;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_addr = '0;
	logic [3:0]   cfg_data = '0;

	logic [3:0]  dir_offset_bits;
	logic [3:0]  dir_set_bits;
	logic [3:0]  dir_ways;
	logic        dir_valid [2048];
	logic        dir_dirty [2048];
	logic [31:0] dir_tag [2048];
	logic [31:0] dir_used [2048];
	logic [31:0] dir_cnt [6];

	access_result_t pending_results[$];
	int errors = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_cnt = 0;
	logic [31:0] stamp_next = 32'd1;
	logic [31:0] addr_pool [12];

	set_assoc_cache_lru_writeback_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // req_type, address, op_index
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),  // outcome, way, prior_valid, prior_dirty, prior_tag,
		                                // prior_last_used, six counters
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
		errors++;
		$display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $time);
	endtask

	function automatic logic [31:0] sat_add(input logic [31:0] c);
		return (c == 32'hffff_ffff) ? c : c + 32'd1;
	endfunction

	task automatic predict_access(input logic st, input logic [31:0] addr, input logic [31:0] stamp);
		access_result_t r;
		int sb, nw, ob, shift, base, hit_way, w;
		logic [63:0] a64;
		logic [31:0] tag;
		ob = dir_offset_bits;
		sb = (dir_set_bits > 8) ? 8 : dir_set_bits;
		nw = (dir_ways == 0) ? 1 : ((dir_ways > 8) ? 8 : dir_ways);
		a64 = {32'd0, addr};
		base = int'((a64 >> ob) & ((64'd1 << sb) - 64'd1)) * 8;
		shift = ob + sb;
		tag = (shift < 32) ? 32'(a64 >> shift) : 32'd0;
		hit_way = -1;
		for (int i = 0; i < nw; i++)
			if (hit_way < 0 && dir_valid[base + i] && dir_tag[base + i] == tag)
				hit_way = i;
		r.outcome = sacl_pkg::OUT_HIT;
		if (hit_way >= 0) begin
			w = hit_way;
		end else begin
			w = -1;
			for (int i = 0; i < nw; i++)
				if (w < 0 && !dir_valid[base + i])
					w = i;
			if (w < 0) begin
				w = 0;
				for (int i = 1; i < nw; i++)
					if (dir_used[base + i] < dir_used[base + w])
						w = i;
			end
			r.outcome = dir_dirty[base + w] ? sacl_pkg::OUT_DIRTY : sacl_pkg::OUT_CLEAN;
		end
		r.way = 3'(w);
		r.prior_valid = dir_valid[base + w];
		r.prior_dirty = dir_dirty[base + w];
		r.prior_tag = dir_valid[base + w] ? dir_tag[base + w] : 32'd0;
		r.prior_last_used = dir_used[base + w];
		if (st)
			dir_cnt[1] = sat_add(dir_cnt[1]);
		else
			dir_cnt[0] = sat_add(dir_cnt[0]);
		if (r.outcome != sacl_pkg::OUT_HIT) begin
			if (st) begin
				dir_cnt[3] = sat_add(dir_cnt[3]);
				if (r.outcome == sacl_pkg::OUT_DIRTY)
					dir_cnt[5] = sat_add(dir_cnt[5]);
			end else begin
				dir_cnt[2] = sat_add(dir_cnt[2]);
				if (r.outcome == sacl_pkg::OUT_DIRTY)
					dir_cnt[4] = sat_add(dir_cnt[4]);
			end
			dir_valid[base + w] = 1'b1;
			dir_dirty[base + w] = 1'b0;
			dir_tag[base + w] = tag;
		end
		dir_used[base + w] = stamp;
		if (st)
			dir_dirty[base + w] = 1'b1;
		r.cnt = dir_cnt;
		pending_results.push_back(r);
	endtask

	task automatic send_access(input logic st, input logic [31:0] addr, input logic [31:0] stamp);
		int gap;
		s_axis_tdata <= {7'd0, stamp, addr, st};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_access(st, addr, stamp);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 8);
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sacl_pkg::REG_OFFSET: dir_offset_bits = val;
			sacl_pkg::REG_SETS: dir_set_bits = val;
			sacl_pkg::REG_WAYS: dir_ways = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [3:0] ob, input logic [3:0] sb, input logic [3:0] nw);
		drain();
		write_reg(sacl_pkg::REG_OFFSET, ob);
		write_reg(sacl_pkg::REG_SETS, sb);
		write_reg(sacl_pkg::REG_WAYS, nw);
	endtask

	task automatic test_directed_lru;
		send_access(1'b0, 32'h0000_0000, 32'd0);
		send_access(1'b1, 32'h0000_0008, 32'd5);
		send_access(1'b0, 32'h0000_0100, 32'd5);
		send_access(1'b0, 32'h0000_0200, 32'd9);
		send_access(1'b0, 32'h0000_0100, 32'd2);
		send_access(1'b1, 32'h0000_0300, 32'd3);
		send_access(1'b1, 32'h0000_0400, 32'hffff_ffff);
		send_access(1'b0, 32'hffff_ffff, 32'hffff_ffff);
		send_access(1'b1, 32'hffff_fff0, 32'd0);
		send_access(1'b0, 32'h7fff_ffff, 32'h8000_0000);
		send_access(1'b1, 32'h0000_0000, 32'd7);
		send_access(1'b0, 32'h0000_0100, 32'd7);
	endtask

	task automatic test_register_extremes;
		configure(4'd15, 4'd15, 4'd15);
		send_access(1'b1, 32'hffff_ffff, 32'd1);
		send_access(1'b0, 32'h0000_7fff, 32'd2);
		send_access(1'b0, 32'h0080_0000, 32'd3);
		send_access(1'b1, 32'hff80_0000, 32'd4);
		configure(4'd0, 4'd0, 4'd0);
		send_access(1'b1, 32'h0000_0001, 32'd1);
		send_access(1'b0, 32'h0000_0002, 32'd1);
		send_access(1'b0, 32'h0000_0001, 32'd2);
		configure(4'd0, 4'd8, 4'd9);
		send_access(1'b0, 32'h0000_00ff, 32'd1);
		send_access(1'b1, 32'h0000_01ff, 32'd1);
	endtask

	task automatic test_random_phase(input logic [3:0] ob, input logic [3:0] sb, input logic [3:0] nw,
		input int items);
		logic [31:0] addr;
		logic [31:0] stamp;
		configure(ob, sb, nw);
		foreach (addr_pool[i])
			addr_pool[i] = $urandom();
		for (int n = 0; n < items; n++) begin
			if ($urandom_range(0, 9) < 8)
				addr = addr_pool[$urandom_range(0, 11)] ^ ($urandom() & ((32'd1 << ob) - 32'd1));
			else
				addr = $urandom();
			if ($urandom_range(0, 9) == 0) begin
				stamp = $urandom();
			end else begin
				stamp = stamp_next;
				stamp_next = stamp_next + $urandom_range(0, 3);
			end
			send_access(1'($urandom_range(0, 1)), addr, stamp);
		end
	endtask

	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 50 == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	always @(posedge clk) begin
		access_result_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report("unexpected transaction", 32'd0, 32'd1);
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tdata[1:0] != e.outcome)
					report("outcome", 32'(e.outcome), 32'(m_axis_tdata[1:0]));
				if (m_axis_tdata[4:2] != e.way)
					report("way", 32'(e.way), 32'(m_axis_tdata[4:2]));
				if (m_axis_tdata[5] != e.prior_valid)
					report("prior_valid", 32'(e.prior_valid), 32'(m_axis_tdata[5]));
				if (m_axis_tdata[6] != e.prior_dirty)
					report("prior_dirty", 32'(e.prior_dirty), 32'(m_axis_tdata[6]));
				if (m_axis_tdata[38:7] != e.prior_tag)
					report("prior_tag", e.prior_tag, m_axis_tdata[38:7]);
				if (m_axis_tdata[70:39] != e.prior_last_used)
					report("prior_last_used", e.prior_last_used, m_axis_tdata[70:39]);
				for (int i = 0; i < 6; i++)
					if (m_axis_tdata[71 + 32 * i +: 32] != e.cnt[i])
						report($sformatf("counter %0d", i), e.cnt[i], m_axis_tdata[71 + 32 * i +: 32]);
			end
		end
	end

	initial begin
		dir_offset_bits = 4'd4;
		dir_set_bits = 4'd4;
		dir_ways = 4'd2;
		foreach (dir_valid[i]) begin
			dir_valid[i] = 1'b0;
			dir_dirty[i] = 1'b0;
			dir_tag[i] = '0;
			dir_used[i] = '0;
		end
		foreach (dir_cnt[i])
			dir_cnt[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lru();
		test_register_extremes();
		test_random_phase(4'd4, 4'd4, 4'd2, 60);
		test_random_phase(4'd0, 4'd0, 4'd1, 50);
		test_random_phase(4'd12, 4'd8, 4'd8, 55);
		test_random_phase(4'd15, 4'd15, 4'd15, 50);
		test_random_phase(4'd2, 4'd1, 4'd0, 45);
		test_random_phase(4'd6, 4'd3, 4'd4, 60);
		test_random_phase(4'd0, 4'd8, 4'd9, 45);
		test_random_phase(4'd3, 4'd2, 4'd8, 55);
		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
